@@ design/sle_pkg.sv @@
// Shared types and constants for the sequential list engine.
// Depends on nothing; used by sle_cell and sequential_list_engine.
`default_nettype none
package sle_pkg;

  localparam int unsigned CAPACITY_DEF = 128;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned VAL_W        = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_GET    = 2'd3
  } cmd_t;

  // Operation broadcast to every cell while a transfer is at work.
  typedef struct packed {
    cmd_t              cmd;
    logic              en;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
  } ctl_t;

  // Wave handed from one cell to the next.
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [POS_W-1:0]  hitpos;
    logic [VAL_W-1:0]  carry;
  } wave_t;

endpackage
`default_nettype wire

@@ design/sle_cell.sv @@
// One list slot: holds an entry and acts on the wave as it passes.
// Depends on sle_pkg.
`default_nettype none
module sle_cell #(
  parameter int unsigned CW  = 8,
  parameter int unsigned IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sle_pkg::ctl_t     ctl,
  input  wire logic [CW-1:0]     cnt,
  input  wire sle_pkg::wave_t    w_in,
  input  wire logic [sle_pkg::VAL_W-1:0] nbr,
  output sle_pkg::wave_t         w_out,
  output logic [sle_pkg::VAL_W-1:0] entry
);

  localparam int unsigned IW = (CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W;
  localparam logic [IW-1:0] IDX1 = IW'(IDX + 1);

  logic [sle_pkg::VAL_W-1:0] entry_r, entry_nxt;
  sle_pkg::wave_t            wave_r, wave_nxt;
  logic [IW-1:0]             pos_ext, cnt_ext;

  assign pos_ext = IW'(ctl.pos);
  assign cnt_ext = IW'(cnt);

  always_comb begin
    entry_nxt = entry_r;
    wave_nxt  = w_in;
    if (w_in.valid && ctl.en) begin
      unique case (ctl.cmd)
        sle_pkg::CMD_INSERT: begin
          if (IDX1 >= pos_ext) begin
            entry_nxt      = w_in.carry;
            wave_nxt.carry = entry_r;
          end
        end
        sle_pkg::CMD_DELETE: begin
          if (IDX1 >= pos_ext) begin
            entry_nxt = nbr;
          end
        end
        sle_pkg::CMD_SEARCH: begin
          if (!w_in.hit && (IDX1 <= cnt_ext) && (entry_r == ctl.value)) begin
            wave_nxt.hit    = 1'b1;
            wave_nxt.hitpos = sle_pkg::POS_W'(IDX + 1);
          end
        end
        sle_pkg::CMD_GET: begin
          if (IDX1 == pos_ext) begin
            wave_nxt.carry = entry_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      wave_r <= '0;
    end else begin
      wave_r <= wave_nxt;
    end
  end

  assign w_out = wave_r;
  assign entry = entry_r;

endmodule
`default_nettype wire

@@ design/sequential_list_engine.sv @@
// Ordered list engine: a row of CAPACITY cells swept by one wave per transfer.
// No new item is taken until the result has moved to the output register; the wave crosses one cell a cycle.
// A finished result may wait at the output while the next item is taken.
// Reset (rst_n, synchronous) empties the list; entries are not cleared.
`default_nettype none
module sequential_list_engine #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic [sle_pkg::POS_W-1:0]   in_position,
  input  wire logic signed [sle_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_ok,
  output logic [sle_pkg::POS_W-1:0]        out_found_position,
  output logic signed [sle_pkg::VAL_W-1:0] out_read_value,
  output logic [sle_pkg::POS_W-1:0]        out_entry_count
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CW > sle_pkg::POS_W) ? CW + 1 : sle_pkg::POS_W + 1;
  localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);

  typedef struct packed {
    logic                      ok;
    logic [sle_pkg::POS_W-1:0] found;
    logic [sle_pkg::VAL_W-1:0] rd;
  } res_t;

  logic [CW-1:0]   count_r, count_nxt, oldcnt_r;
  sle_pkg::ctl_t   ctl_r;
  sle_pkg::wave_t  start_r;
  logic            busy_r;
  logic            pend_r;
  res_t            pend_d_r, res_now;
  logic            out_valid_r;
  res_t            out_d_r;
  logic [CW-1:0]   out_cnt_r;

  sle_pkg::wave_t            wave [CAPACITY+1];
  logic [sle_pkg::VAL_W-1:0] ent  [CAPACITY];

  logic          accept, out_free;
  sle_pkg::cmd_t cmd_in;
  logic [IW-1:0] pos_i, cnt_i;
  logic          ok_in;

  assign accept   = in_valid && !busy_r;
  assign out_free = !out_valid_r || !out_stall;
  assign cmd_in   = sle_pkg::cmd_t'(in_cmd);
  assign pos_i    = IW'(in_position);
  assign cnt_i    = IW'(count_r);

  always_comb begin
    ok_in     = 1'b0;
    count_nxt = count_r;
    unique case (cmd_in)
      sle_pkg::CMD_INSERT: begin
        ok_in = (cnt_i < CAP_I) && (pos_i != '0) && (pos_i <= cnt_i + IW'(1));
        if (ok_in) count_nxt = count_r + CW'(1);
      end
      sle_pkg::CMD_DELETE: begin
        ok_in = (pos_i != '0) && (pos_i <= cnt_i);
        if (ok_in) count_nxt = count_r - CW'(1);
      end
      sle_pkg::CMD_SEARCH: ok_in = 1'b1;
      sle_pkg::CMD_GET:    ok_in = (pos_i != '0) && (pos_i <= cnt_i);
      default: ;
    endcase
  end

  assign wave[0] = start_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sle_cell #(.CW(CW), .IDX(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl_r),
      .cnt   (oldcnt_r),
      .w_in  (wave[i]),
      .nbr   (ent[(i + 1 < CAPACITY) ? i + 1 : i]),
      .w_out (wave[i+1]),
      .entry (ent[i])
    );
  end

  always_comb begin
    res_now.ok    = (ctl_r.cmd == sle_pkg::CMD_SEARCH) ? wave[CAPACITY].hit : ctl_r.en;
    res_now.found = wave[CAPACITY].hit ? wave[CAPACITY].hitpos : '0;
    res_now.rd    = (ctl_r.cmd == sle_pkg::CMD_GET && ctl_r.en) ?
                    wave[CAPACITY].carry : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      busy_r        <= 1'b0;
      start_r.valid <= 1'b0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      start_r.valid <= accept;
      if (accept) begin
        busy_r         <= 1'b1;
        count_r        <= count_nxt;
        oldcnt_r       <= count_r;
        ctl_r.cmd      <= cmd_in;
        ctl_r.en       <= ok_in;
        ctl_r.pos      <= in_position;
        ctl_r.value    <= in_value;
        start_r.hit    <= 1'b0;
        start_r.hitpos <= '0;
        start_r.carry  <= (cmd_in == sle_pkg::CMD_GET) ? '0 : in_value;
      end
      if (wave[CAPACITY].valid) begin
        pend_r   <= 1'b1;
        pend_d_r <= res_now;
      end
      if (out_free) begin
        out_valid_r <= pend_r;
        if (pend_r) begin
          out_d_r   <= pend_d_r;
          out_cnt_r <= count_r;
          pend_r    <= 1'b0;
          busy_r    <= 1'b0;
        end
      end
    end
  end

  assign in_stall           = busy_r;
  assign out_valid          = out_valid_r;
  assign out_ok             = out_d_r.ok;
  assign out_found_position = out_d_r.found;
  assign out_read_value     = out_d_r.rd;
  assign out_entry_count    = sle_pkg::POS_W'(out_cnt_r);

endmodule
`default_nettype wire
